[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[rtl/core/chgw_pkg.sv]
// ---------------------------------------------------------------------------
// chgw_pkg
// shared types and constants of the gift-wrap hull block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package chgw_pkg;

  // point count width, holds any store depth up to 127
  localparam int unsigned CNT_W = 7;
  // sets of this size or smaller are replayed as given
  localparam int unsigned SMALL_SET = 3;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

[rtl/core/convex_hull_gift_wrap.sv]
// ---------------------------------------------------------------------------
// convex_hull_gift_wrap
// streaming convex hull by gift wrapping over a stored point set
// ---------------------------------------------------------------------------
// points stream in one per cycle and are kept in an on-chip store of
// MAX_POINTS entries; the transaction with tlast closes the set. the march
// engine then finds the leftmost point (earliest on ties) and walks the
// hull: for each hull step every point passes through the difference,
// multiply and compare stages, with one store read per point. a set of
// three or fewer points is replayed in arrival order. input is held off
// from the closing transaction until the last hull point has been loaded
// into the output register. points past capacity are dropped and every
// result of that set carries tuser high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module convex_hull_gift_wrap #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // point_x, point_y, zero padding
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // final_point
  input  logic                               s_axis_tlast_i,
  // hull_x, hull_y, zero padding
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // last_hull_point
  output logic                               m_axis_tlast_o,
  // points_dropped
  output logic                               m_axis_tuser_o
);
  import chgw_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_POINTS);
  localparam int unsigned TDW  = ((2*COORD_WIDTH+7)/8)*8;

  // store write port, loader to engine
  logic                         wr_en;
  logic [IDXW-1:0]              wr_addr;
  logic signed [COORD_WIDTH-1:0] wr_x, wr_y;

  // job queue
  logic         job_push, job_pop, q_empty, q_full;
  job_t         job_in, job_out;
  back_status_t back_st;

  logic signed [COORD_WIDTH-1:0] out_x, out_y;

  chgw_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .x_i      (s_axis_tdata_i[COORD_WIDTH-1:0]),
    .y_i      (s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]),
    .final_i  (s_axis_tlast_i),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_x_o   (wr_x),
    .wr_y_o   (wr_y),
    .push_o   (job_push),
    .job_o    (job_in),
    .done_i   (back_st.done)
  );

  // set descriptors wait here until the engine is free
  chgw_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  chgw_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_x_i     (wr_x),
    .wr_y_i     (wr_y),
    .job_valid_i(!q_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .status_o   (back_st),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_last_o (m_axis_tlast_o),
    .out_drop_o (m_axis_tuser_o)
  );

  // coordinates in the low bits, padding zero
  assign m_axis_tdata_o = TDW'({out_y, out_x});

  // no point may land in the store while a set is being marched
  `ASSERT_NEVER(a_no_load_busy, clk_i, rst_ni,
                s_axis_tvalid_i && s_axis_tready_o && back_st.busy)
  // the loader never offers a set the queue cannot hold
  `ASSERT_NEVER(a_jobq_no_overflow, clk_i, rst_ni, job_push && q_full)
  // a finished set leaves nothing queued behind it
  `ASSERT_PROP(a_done_queue_empty, clk_i, rst_ni, back_st.done |-> q_empty)

endmodule

[rtl/core/chgw_front.sv]
// ---------------------------------------------------------------------------
// chgw_front
// point loader: stores points, tracks overflow, issues one job per set
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module chgw_front #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [COORD_WIDTH-1:0]    x_i,
  input  logic signed [COORD_WIDTH-1:0]    y_i,
  input  logic                             final_i,
  output logic                             wr_en_o,
  output logic [$clog2(MAX_POINTS)-1:0]    wr_addr_o,
  output logic signed [COORD_WIDTH-1:0]    wr_x_o,
  output logic signed [COORD_WIDTH-1:0]    wr_y_o,
  output logic                             push_o,
  output chgw_pkg::job_t                   job_o,
  input  logic                             done_i
);
  import chgw_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_POINTS);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             lock_q, lock_d;
  logic             accept, full;
  logic [CNT_W-1:0] cnt_after;
  logic             ovf_after;

  assign ready_o   = !lock_q;
  assign accept    = valid_i && ready_o;
  assign full      = (cnt_q == CNT_W'(MAX_POINTS));
  assign cnt_after = full ? cnt_q : cnt_q + CNT_W'(1);
  assign ovf_after = ovf_q | full;

  assign wr_en_o   = accept && !full;
  assign wr_addr_o = cnt_q[IDXW-1:0];
  assign wr_x_o    = x_i;
  assign wr_y_o    = y_i;
  assign push_o    = accept && final_i;
  assign job_o     = '{count: cnt_after, ovf: ovf_after};

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    lock_d = lock_q;
    if (done_i) begin
      lock_d = 1'b0;
    end
    if (accept) begin
      if (final_i) begin
        cnt_d  = '0;
        ovf_d  = 1'b0;
        lock_d = 1'b1;
      end else begin
        cnt_d = cnt_after;
        ovf_d = ovf_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      lock_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      lock_q <= lock_d;
    end
  end

endmodule

[rtl/core/chgw_jobq.sv]
// ---------------------------------------------------------------------------
// chgw_jobq
// two-entry queue of set descriptors between loader and march engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module chgw_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  chgw_pkg::job_t job_i,
  input  logic           pop_i,
  output chgw_pkg::job_t job_o,
  output logic           empty_o,
  output logic           full_o
);
  import chgw_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign empty_o = (fill_q == 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/core/chgw_back.sv]
// ---------------------------------------------------------------------------
// chgw_back
// march engine: point store, leftmost search, turn test and hull output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module chgw_back #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [$clog2(MAX_POINTS)-1:0]    wr_addr_i,
  input  logic signed [COORD_WIDTH-1:0]    wr_x_i,
  input  logic signed [COORD_WIDTH-1:0]    wr_y_i,
  input  logic                             job_valid_i,
  input  chgw_pkg::job_t                   job_i,
  output logic                             job_pop_o,
  output chgw_pkg::back_status_t           status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COORD_WIDTH-1:0]    out_x_o,
  output logic signed [COORD_WIDTH-1:0]    out_y_o,
  output logic                             out_last_o,
  output logic                             out_drop_o
);
  import chgw_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_POINTS);
  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned PW   = 2 * W + 2;
  localparam int unsigned SW   = 2 * W + 3;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SM_RD  = 11'b000_0000_0010,
    ST_SM_OUT = 11'b000_0000_0100,
    ST_FIND   = 11'b000_0000_1000,
    ST_C_RD   = 11'b000_0001_0000,
    ST_C_WT   = 11'b000_0010_0000,
    ST_E_WT   = 11'b000_0100_0000,
    ST_P_DIF  = 11'b000_1000_0000,
    ST_P_MUL  = 11'b001_0000_0000,
    ST_P_CMP  = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [2*W-1:0] mem [MAX_POINTS];
  logic [2*W-1:0] rdata_q;
  logic           rd_en;
  logic [IDXW-1:0] rd_addr;

  logic [CNT_W-1:0] n_q, k_q, steps_q, fidx_q;
  logic             ovf_q, fvld_q;
  logic [IDXW-1:0]  start_q, cur_q, cand_q;
  logic signed [W-1:0] minx_q, cx_q, cy_q, ex_q, ey_q, px_q, py_q;
  logic signed [W:0]   dix_q, diy_q, dex_q, dey_q;
  logic signed [PW-1:0] m1_q, m2_q, sqi1_q, sqi2_q, sqe1_q, sqe2_q;
  logic                out_valid_q, out_last_q, out_drop_q;
  logic signed [W-1:0] out_x_q, out_y_q;

  logic signed [W-1:0] rx, ry;
  logic signed [SW-1:0] turn, di, de;
  logic                 replace, out_free, emit_last;
  logic                 done;

  assign rx = $signed(rdata_q[W-1:0]);
  assign ry = $signed(rdata_q[2*W-1:W]);

  // store address of a working index: position 0 and the start point trade places
  function automatic logic [IDXW-1:0] map_idx(input logic [IDXW-1:0] w,
                                              input logic [IDXW-1:0] s);
    logic [IDXW-1:0] r;
    if (w == '0) r = s;
    else if (w == s) r = '0;
    else r = w;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_y_i, wr_x_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign turn = {m1_q[PW-1], m1_q} - {m2_q[PW-1], m2_q};
  assign di   = {sqi1_q[PW-1], sqi1_q} + {sqi2_q[PW-1], sqi2_q};
  assign de   = {sqe1_q[PW-1], sqe1_q} + {sqe2_q[PW-1], sqe2_q};
  assign replace = (turn > 0) || ((turn == 0) && (di > de));

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (cand_q == '0) || ((steps_q + CNT_W'(1)) >= n_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.count <= CNT_W'(SMALL_SET)) ? ST_SM_RD : ST_FIND;
        end
      end
      ST_SM_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q[IDXW-1:0];
        state_d = ST_SM_OUT;
      end
      ST_SM_OUT: begin
        if (out_free) begin
          state_d = ((k_q + CNT_W'(1)) == n_q) ? ST_IDLE : ST_SM_RD;
        end
      end
      ST_FIND: begin
        rd_en   = (k_q < n_q);
        rd_addr = k_q[IDXW-1:0];
        if (k_q == n_q && !fvld_q) begin
          state_d = ST_C_RD;
        end
      end
      ST_C_RD: begin
        rd_en   = 1'b1;
        rd_addr = map_idx(cur_q, start_q);
        state_d = ST_C_WT;
      end
      ST_C_WT: begin
        rd_en   = 1'b1;
        rd_addr = start_q;
        state_d = ST_E_WT;
      end
      ST_E_WT: begin
        rd_en   = 1'b1;
        rd_addr = map_idx(IDXW'(1), start_q);
        state_d = ST_P_DIF;
      end
      ST_P_DIF: state_d = ST_P_MUL;
      ST_P_MUL: state_d = ST_P_CMP;
      ST_P_CMP: begin
        if ((k_q + CNT_W'(1)) < n_q) begin
          rd_en   = 1'b1;
          rd_addr = map_idx(k_q[IDXW-1:0] + IDXW'(1), start_q);
          state_d = ST_P_DIF;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = emit_last ? ST_IDLE : ST_C_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign done      = ((state_q == ST_SM_OUT) && out_free
                      && ((k_q + CNT_W'(1)) == n_q))
                  || ((state_q == ST_EMIT) && out_free && emit_last);
  assign status_o  = '{busy: (state_q != ST_IDLE), done: done};

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        n_q     <= job_i.count;
        ovf_q   <= job_i.ovf;
        k_q     <= '0;
        steps_q <= '0;
        cur_q   <= '0;
        start_q <= '0;
      end
      ST_SM_OUT: begin
        if (out_free) k_q <= k_q + CNT_W'(1);
      end
      ST_FIND: begin
        if (k_q < n_q) begin
          k_q    <= k_q + CNT_W'(1);
          fidx_q <= k_q;
        end
        if (fvld_q && (fidx_q == '0 || rx < minx_q)) begin
          minx_q  <= rx;
          start_q <= fidx_q[IDXW-1:0];
        end
      end
      ST_C_WT: begin
        cx_q <= rx;
        cy_q <= ry;
      end
      ST_E_WT: begin
        ex_q   <= rx;
        ey_q   <= ry;
        cand_q <= '0;
        k_q    <= CNT_W'(1);
      end
      ST_P_DIF: begin
        px_q  <= rx;
        py_q  <= ry;
        dix_q <= {rx[W-1], rx} - {cx_q[W-1], cx_q};
        diy_q <= {ry[W-1], ry} - {cy_q[W-1], cy_q};
        dex_q <= {ex_q[W-1], ex_q} - {cx_q[W-1], cx_q};
        dey_q <= {ey_q[W-1], ey_q} - {cy_q[W-1], cy_q};
      end
      ST_P_MUL: begin
        m1_q   <= dix_q * dey_q;
        m2_q   <= dex_q * diy_q;
        sqi1_q <= dix_q * dix_q;
        sqi2_q <= diy_q * diy_q;
        sqe1_q <= dex_q * dex_q;
        sqe2_q <= dey_q * dey_q;
      end
      ST_P_CMP: begin
        if (replace) begin
          cand_q <= k_q[IDXW-1:0];
          ex_q   <= px_q;
          ey_q   <= py_q;
        end
        k_q <= k_q + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          steps_q <= steps_q + CNT_W'(1);
          cur_q   <= cand_q;
        end
      end
      default: begin
      end
    endcase
  end

  // state register, find pipeline valid and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fvld_q  <= (state_q == ST_FIND) && (k_q < n_q);
      if (out_ready_i) out_valid_q <= 1'b0;
      if ((state_q == ST_SM_OUT || state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SM_OUT && out_free) begin
      out_x_q    <= rx;
      out_y_q    <= ry;
      out_last_q <= ((k_q + CNT_W'(1)) == n_q);
      out_drop_q <= ovf_q;
    end else if (state_q == ST_EMIT && out_free) begin
      out_x_q    <= cx_q;
      out_y_q    <= cy_q;
      out_last_q <= emit_last;
      out_drop_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the gift-wrap convex hull block
// ---------------------------------------------------------------------------
// point sets are streamed in, an in-bench hull walk predicts the emitted hull
// points, and a monitor compares every result transaction in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NPTS  = 64;
  localparam int unsigned CW    = 16;
  localparam int unsigned DW    = ((2*CW+7)/8)*8;
  localparam int unsigned SMALL = chgw_pkg::SMALL_SET;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
    logic                 dropped;
  } hull_pt_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic [DW-1:0] s_axis_tdata_i = '0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic          s_axis_tlast_i = 1'b0;
  logic [DW-1:0] m_axis_tdata_o;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic          m_axis_tlast_o;
  logic          m_axis_tuser_o;

  // gap rates in percent
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned n_mismatch = 0;

  // predictor state
  logic signed [CW-1:0] set_x[NPTS];
  logic signed [CW-1:0] set_y[NPTS];
  int unsigned set_count = 0;
  bit          set_overflow = 1'b0;
  hull_pt_t    hull_queue[$];

  convex_hull_gift_wrap #(.MAX_POINTS(NPTS), .COORD_WIDTH(CW)) DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint turn(int cx, int cy, int ix, int iy, int ex, int ey);
    return (longint'(ix - cx) * longint'(ey - cy)) - (longint'(ex - cx) * longint'(iy - cy));
  endfunction

  function automatic longint dsq(int ax, int ay, int bx, int by);
    return longint'(ax - bx) * longint'(ax - bx) + longint'(ay - by) * longint'(ay - by);
  endfunction

  // store a point and, on the closing point, queue the expected hull
  task automatic predict_hull(input logic signed [CW-1:0] px, py, input bit fin);
    int wx[NPTS];
    int wy[NPTS];
    int idx[$];
    int n, lo, tmp, cur, cand, steps;
    longint t;
    hull_pt_t h;
    if (set_count < NPTS) begin
      set_x[set_count] = px;
      set_y[set_count] = py;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!fin) return;
    n = set_count;
    if (n <= SMALL) begin
      for (int k = 0; k < n; k++) begin
        h = '{set_x[k], set_y[k], k == n - 1, set_overflow};
        hull_queue.push_back(h);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        wx[k] = set_x[k];
        wy[k] = set_y[k];
      end
      lo = 0;
      for (int k = 0; k < n; k++) if (wx[k] < wx[lo]) lo = k;
      tmp = wx[0]; wx[0] = wx[lo]; wx[lo] = tmp;
      tmp = wy[0]; wy[0] = wy[lo]; wy[lo] = tmp;
      cur = 0;
      steps = 0;
      forever begin
        idx.push_back(cur);
        steps++;
        cand = 0;
        for (int k = 1; k < n; k++) begin
          t = turn(wx[cur], wy[cur], wx[k], wy[k], wx[cand], wy[cand]);
          if (t > 0) cand = k;
          else if (t == 0 && dsq(wx[cur], wy[cur], wx[cand], wy[cand]) <
                   dsq(wx[cur], wy[cur], wx[k], wy[k])) cand = k;
        end
        cur = cand;
        if (cur == 0 || steps >= n) break;
      end
      for (int k = 0; k < steps; k++) begin
        h = '{CW'(wx[idx[k]]), CW'(wy[idx[k]]), k == steps - 1, set_overflow};
        hull_queue.push_back(h);
      end
    end
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  // one point transaction, gaps before it at the current rate
  task automatic send_point(input logic signed [CW-1:0] px, py, input bit fin);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= {{(DW-2*CW){1'b0}}, py, px};
    s_axis_tlast_i  <= fin;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_hull(px, py, fin);
  endtask

  // receiver stalls and result check
  always @(posedge clk_i) begin
    hull_pt_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[CW-1:0], m_axis_tdata_o[2*CW-1:CW], m_axis_tlast_o,
              m_axis_tuser_o};
      if (hull_queue.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected hull point %p", got);
      end else begin
        want = hull_queue.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("hull point mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= recv_gap_pct);
  end

  function automatic logic signed [CW-1:0] rnd_coord(input int unsigned spread);
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(2*spread)) - $signed(spread));
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return CW'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  task automatic send_set(input int unsigned n, input int unsigned spread);
    for (int k = 0; k < n; k++) send_point(rnd_coord(spread), rnd_coord(spread), k == n - 1);
  endtask

  task automatic test_small_sets();
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b1);
    send_point(3, 4, 1'b0);
    send_point(-3, 4, 1'b0);
    send_point(5, -5, 1'b1);
  endtask

  task automatic test_extremes();
    // corners plus collinear, duplicate and interior points; ties on leftmost x
    send_point(16'sh8000, 16'sh0000, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(16'sh7fff, 0, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
    // all points on one line
    send_point(0, 0, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(4, 4, 1'b0);
    send_point(1, 1, 1'b1);
  endtask

  task automatic test_overflow();
    // full store then dropped points, closing point dropped too; also a set that exactly fills the store
    send_set(NPTS + 3, 1000);
    send_set(NPTS, 50);
    send_set(NPTS + 1, 30000);
  endtask

  task automatic test_random(input int unsigned items);
    int unsigned sent = 0, n;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(NPTS) + 1 : $urandom_range(12) + 1;
      send_set(n, $urandom_range(1) ? 20 : 20000);
      sent += n;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 20; recv_gap_pct = 77;
    test_small_sets();
    test_extremes();
    test_overflow();
    test_random(65);
    send_gap_pct = 77; recv_gap_pct = 20;
    test_random(65);
    send_gap_pct = 0; recv_gap_pct = 0;
    test_random(60);
    s_axis_tvalid_i <= 1'b0;
    while (hull_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_mismatch == 0) $display("convex_hull_gift_wrap regression: pass");
    else $display("convex_hull_gift_wrap regression: fail");
    $finish;
  end

  // watchdog, march runs up to 64 hull steps per set
  initial begin
    #200ms;
    $display("convex_hull_gift_wrap regression: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/chgw_pkg.sv
rtl/core/chgw_front.sv
rtl/core/chgw_jobq.sv
rtl/core/chgw_back.sv
rtl/core/convex_hull_gift_wrap.sv
sim/tb.sv
